### hdl/jsu_pkg.sv
package jsu_pkg;

    // Input and result items.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } t_out_item;

    // Result kinds and error codes.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] ERR_CHAR = 2'd0;
    localparam logic [1:0] ERR_XHEX = 2'd1;
    localparam logic [1:0] ERR_UNI  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ESC_B  = 8'h62;
    localparam logic [7:0] CH_ESC_F  = 8'h66;
    localparam logic [7:0] CH_ESC_N  = 8'h6E;
    localparam logic [7:0] CH_ESC_T  = 8'h74;
    localparam logic [7:0] CH_ESC_R  = 8'h72;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // Code point limits.
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_MAX_1B   = 21'h0007F;
    localparam logic [20:0] CP_MAX_2B   = 21'h007FF;
    localparam logic [20:0] CP_MAX_3B   = 21'h0FFFF;

    // UTF-8 lead and continuation marks.
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    // Work queue between the decoder and the result sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queue entry holds all results caused by one input byte.
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] data;
        logic [1:0]      kind;
        logic [1:0]      code;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] data;
    } t_utf8;

    // Returns {bad, value}.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] res;
        res = 5'b1_0000;
        if (b inside {[CH_DIGIT0:CH_DIGIT9]}) begin
            res = {1'b0, 4'(b - CH_DIGIT0)};
        end else if (b inside {[CH_LC_A:CH_LC_F]}) begin
            res = {1'b0, 4'(b - CH_LC_A) + 4'd10};
        end else if (b inside {[CH_UC_A:CH_UC_F]}) begin
            res = {1'b0, 4'(b - CH_UC_A) + 4'd10};
        end
        return res;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] b);
        logic [7:0] res;
        case (b)
            CH_ESC_B: res = CH_BS;
            CH_ESC_F: res = CH_FF;
            CH_ESC_N: res = CH_LF;
            CH_ESC_T: res = CH_TAB;
            CH_ESC_R: res = CH_CR;
            default:  res = b;
        endcase
        return res;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 res;
        res = '0;
        if (cp <= CP_MAX_1B) begin
            res.data[0]  = cp[7:0];
            res.last_idx = 2'd0;
        end else if (cp <= CP_MAX_2B) begin
            res.data[0]  = UTF_LEAD2 | {3'b000, cp[10:6]};
            res.data[1]  = UTF_CONT | {2'b00, cp[5:0]};
            res.last_idx = 2'd1;
        end else if (cp <= CP_MAX_3B) begin
            res.data[0]  = UTF_LEAD3 | {4'b0000, cp[15:12]};
            res.data[1]  = UTF_CONT | {2'b00, cp[11:6]};
            res.data[2]  = UTF_CONT | {2'b00, cp[5:0]};
            res.last_idx = 2'd2;
        end else begin
            res.data[0]  = UTF_LEAD4 | {5'b00000, cp[20:18]};
            res.data[1]  = UTF_CONT | {2'b00, cp[17:12]};
            res.data[2]  = UTF_CONT | {2'b00, cp[11:6]};
            res.data[3]  = UTF_CONT | {2'b00, cp[5:0]};
            res.last_idx = 2'd3;
        end
        return res;
    endfunction

endpackage

### hdl/jsu_front.sv
module jsu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jsu_pkg::t_in_item  i_in_item,
    input  jsu_pkg::t_q_status i_q_status,
    output logic               o_push,
    output jsu_pkg::t_job      o_job
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_BODY, M_ESC, M_XHEX, M_UHEX1, M_WANT_BS, M_WANT_U, M_UHEX2
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_digits, n_digits;
    logic [15:0] r_accum, n_accum;
    logic [9:0]  r_high, n_high;

    logic        w_accept;
    logic        w_has_result;
    t_job        w_job;

    always_comb begin
        t_mode       cur_mode;
        logic [1:0]  cur_digits;
        logic [15:0] cur_accum;
        logic [9:0]  cur_high;
        logic [7:0]  b;
        logic [4:0]  hex;
        logic [7:0]  accum_x;
        logic [15:0] accum_u;
        logic [20:0] cp_pair;
        t_utf8       enc;

        b          = i_in_item.in_byte;
        cur_mode   = i_in_item.first_byte ? M_BODY : r_mode;
        cur_digits = i_in_item.first_byte ? 2'd0 : r_digits;
        cur_accum  = i_in_item.first_byte ? 16'd0 : r_accum;
        cur_high   = i_in_item.first_byte ? 10'd0 : r_high;
        hex        = hex_value(b);
        accum_x    = {cur_accum[3:0], hex[3:0]};
        accum_u    = {cur_accum[11:0], hex[3:0]};
        cp_pair    = SUPP_BASE + {1'b0, cur_high, accum_u[9:0]};
        enc        = '0;

        n_mode       = cur_mode;
        n_digits     = cur_digits;
        n_accum      = cur_accum;
        n_high       = cur_high;
        w_has_result = 1'b0;
        w_job        = '0;
        w_job.kind   = KIND_DATA;
        w_job.code   = ERR_CHAR;

        case (cur_mode)
            M_BODY: begin
                w_has_result = (b != CH_BSLASH);
                if (b == CH_NUL || b == CH_LF) begin
                    n_mode     = M_IDLE;
                    n_digits   = '0;
                    n_accum    = '0;
                    n_high     = '0;
                    w_job.kind = KIND_ERR;
                    w_job.code = ERR_CHAR;
                end else if (b == CH_QUOTE) begin
                    n_mode     = M_IDLE;
                    w_job.kind = KIND_DONE;
                end else if (b == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    w_job.data[0] = b;
                end
            end
            M_ESC: begin
                n_digits = '0;
                n_accum  = '0;
                if (b == CH_X) begin
                    n_mode = M_XHEX;
                end else if (b == CH_U) begin
                    n_mode = M_UHEX1;
                end else begin
                    n_mode        = M_BODY;
                    w_has_result  = 1'b1;
                    w_job.data[0] = escape_char(b);
                end
            end
            M_XHEX: begin
                if (hex[4]) begin
                    n_mode       = M_IDLE;
                    n_digits     = '0;
                    n_accum      = '0;
                    n_high       = '0;
                    w_has_result = 1'b1;
                    w_job.kind   = KIND_ERR;
                    w_job.code   = ERR_XHEX;
                end else begin
                    n_accum = {8'd0, accum_x};
                    if (cur_digits == 2'd1) begin
                        n_mode        = M_BODY;
                        n_digits      = '0;
                        w_has_result  = 1'b1;
                        w_job.data[0] = accum_x;
                    end else begin
                        n_digits = 2'd1;
                    end
                end
            end
            M_UHEX1, M_UHEX2: begin
                if (hex[4]) begin
                    n_mode       = M_IDLE;
                    n_digits     = '0;
                    n_accum      = '0;
                    n_high       = '0;
                    w_has_result = 1'b1;
                    w_job.kind   = KIND_ERR;
                    w_job.code   = ERR_UNI;
                end else begin
                    n_accum = accum_u;
                    if (cur_digits != 2'd3) begin
                        n_digits = cur_digits + 2'd1;
                    end else begin
                        n_digits = '0;
                        if (cur_mode == M_UHEX1 &&
                            accum_u inside {[SURR_HI_MIN:SURR_HI_MAX]}) begin
                            // High surrogate: hold its payload and wait for \u.
                            n_high  = accum_u[9:0];
                            n_accum = '0;
                            n_mode  = M_WANT_BS;
                        end else begin
                            n_mode = M_BODY;
                            if (cur_mode == M_UHEX1) begin
                                enc = utf8_encode({5'd0, accum_u});
                            end else begin
                                enc = utf8_encode(cp_pair);
                            end
                            w_has_result   = 1'b1;
                            w_job.data     = enc.data;
                            w_job.last_idx = enc.last_idx;
                        end
                    end
                end
            end
            M_WANT_BS, M_WANT_U: begin
                if ((cur_mode == M_WANT_BS && b != CH_BSLASH) ||
                    (cur_mode == M_WANT_U && b != CH_U)) begin
                    n_mode       = M_IDLE;
                    n_digits     = '0;
                    n_accum      = '0;
                    n_high       = '0;
                    w_has_result = 1'b1;
                    w_job.kind   = KIND_ERR;
                    w_job.code   = ERR_UNI;
                end else if (cur_mode == M_WANT_BS) begin
                    n_mode = M_WANT_U;
                end else begin
                    n_mode   = M_UHEX2;
                    n_digits = '0;
                    n_accum  = '0;
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase
    end

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && w_has_result;
    assign o_job      = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_digits <= '0;
            r_accum  <= '0;
            r_high   <= '0;
        end else if (w_accept) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_accum  <= n_accum;
            r_high   <= n_high;
        end
    end

endmodule

### hdl/jsu_queue.sv
module jsu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jsu_pkg::t_job      i_job,
    input  logic               i_pop,
    output jsu_pkg::t_job      o_job,
    output jsu_pkg::t_q_status o_status
);
    import jsu_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### hdl/jsu_back.sv
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_job      i_job,
    input  jsu_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jsu_pkg::t_out_item o_out_item
);
    import jsu_pkg::*;

    logic      r_valid;
    logic [1:0] r_idx;
    t_out_item r_item;
    logic      w_load;
    logic      w_end;

    // Results of one item leave one per cycle while i_out_ready is high, first byte first.
    assign w_load = (!r_valid || i_out_ready) && !i_q_status.empty;
    assign w_end  = (r_idx == i_job.last_idx);
    assign o_pop  = w_load && w_end;

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_end ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.out_byte   <= i_job.data[r_idx];
            r_item.kind       <= i_job.kind;
            r_item.error_code <= i_job.code;
            r_item.last       <= w_end;
        end
    end

endmodule

### hdl/json_string_unescape_utf8.sv
// Channel   Direction  Handshake                  Item
// input     in         i_in_valid / o_in_ready    i_in_item  (in_byte, first_byte)
// result    out        o_out_valid / i_out_ready  o_out_item (out_byte, kind, error_code, last)
//
// One input byte is taken per cycle while the four-entry work queue has room.
// Results leave one per cycle unless the output stalls; a \u escape gives one per UTF-8 byte.
// A taken byte's results are written into the queue, then loaded into the output register.
// Reset (synchronous, active low) idles the decoder and empties the queue and output register.
// An output stall fills the queue, after which o_in_ready drops until an entry leaves.
module json_string_unescape_utf8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jsu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jsu_pkg::t_out_item o_out_item
);
    import jsu_pkg::*;

    // Decoder to queue: a push carries every result of one input byte.
    logic      w_push;
    t_job      w_push_job;

    // Queue head as seen by the result sequencer.
    t_job      w_head_job;
    t_q_status w_q_status;
    logic      w_pop;

    // The front end runs the escape state machine and classifies each byte.
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // The queue decouples the input side from output stalls.
    jsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // The back end walks each queued entry and sends its results in order.
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Done and error results are always the only result of their byte.
    a_ctrl_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind != KIND_DATA) |-> o_out_item.last)
        else $error("done or error result not marked last");

    // Non-data results carry a zero byte; only errors carry an error code.
    a_ctrl_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind != KIND_DATA) |->
        (o_out_item.out_byte == 8'd0 &&
         (o_out_item.kind == KIND_ERR || o_out_item.error_code == ERR_CHAR)))
        else $error("control result carries a payload");

    // A taken result that is not last is followed at once by the next byte.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_item.last) |=> o_out_valid)
        else $error("multi-byte result sequence broken");

    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("work queue overflow");

endmodule
